FILE: hw/rtl/sidec_pkg.sv
package sidec_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] digit_t;

  localparam char_t  CHAR_ZERO       = 8'h30;
  localparam char_t  CHAR_MINUS      = 8'h2D;
  localparam digit_t DIGIT_ADJ_MIN   = 4'd5;
  localparam digit_t DIGIT_ADJ       = 4'd3;
  localparam int     STEPS_PER_STAGE = 4;

endpackage

FILE: hw/rtl/sidec_stage.sv
module sidec_stage
  import sidec_pkg::*;
#(
  parameter int DIGITS   = 10,
  parameter int BIN_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic                  up_negative,
  input  logic [DIGITS*4-1:0]   up_bcd,
  input  logic [BIN_BITS-1:0]   up_bin,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic                  dn_negative,
  output logic [DIGITS*4-1:0]   dn_bcd,
  output logic [BIN_BITS-1:0]   dn_bin
);

  logic [DIGITS*4-1:0] bcd_next;
  logic [BIN_BITS-1:0] bin_next;

  // add-3 then shift, one bit per step
  always_comb begin
    bcd_next = up_bcd;
    bin_next = up_bin;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_next[d*4 +: 4] >= DIGIT_ADJ_MIN) begin
          bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + DIGIT_ADJ;
        end
      end
      {bcd_next, bin_next} = {bcd_next[DIGITS*4-2:0], bin_next, 1'b0};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_negative <= up_negative;
      dn_bcd      <= bcd_next;
      dn_bin      <= bin_next;
    end
  end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_core.sv
// A value word passes the input register, the stages, the held-value register and
// the character register. Output: one character word per cycle while char_ready is
// high; a value occupies the output for its character count, 1 to 11 characters at 32
// bits, set by the single character register. The conversion pipeline takes a new
// value every cycle while it has room. Reset (rst, sync) clears only the valid flags.
module signed_int_to_decimal_ascii_core
  import sidec_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  output logic               value_ready,
  input  logic signed [31:0] value,
  output logic               char_valid,
  input  logic               char_ready,
  output char_t              character,
  output logic               last
);

  localparam int NDIG   = (VALUE_BITS * 3) / 10 + 1;
  localparam int NSTAGE = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int BIN_W  = NSTAGE * STEPS_PER_STAGE;
  localparam int BCD_W  = NDIG * 4;
  localparam int POS_W  = $clog2(NDIG);

  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] mag;

  logic             pv   [0:NSTAGE];
  logic             pr   [0:NSTAGE];
  logic             pneg [0:NSTAGE];
  logic [BCD_W-1:0] pbcd [0:NSTAGE];
  logic [BIN_W-1:0] pbin [0:NSTAGE];

  logic             ev;
  logic             eneg;
  logic [POS_W-1:0] epos;
  logic [BCD_W-1:0] ebcd;
  logic [POS_W-1:0] msd;
  logic             out_load;
  logic             take;
  digit_t           digit;

  assign x   = VALUE_BITS'(value);
  assign mag = x[VALUE_BITS-1] ? (~x + 1'b1) : x;

  assign value_ready = !pv[0] || pr[0];
  assign pbcd[0]     = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (value_ready) begin
      pv[0] <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (value_ready && value_valid) begin
      pneg[0] <= x[VALUE_BITS-1];
      pbin[0] <= BIN_W'(mag);
    end
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    sidec_stage #(
      .DIGITS   (NDIG),
      .BIN_BITS (BIN_W)
    ) u_stage (
      .clk         (clk),
      .rst         (rst),
      .up_valid    (pv[g]),
      .up_ready    (pr[g]),
      .up_negative (pneg[g]),
      .up_bcd      (pbcd[g]),
      .up_bin      (pbin[g]),
      .dn_valid    (pv[g+1]),
      .dn_ready    (pr[g+1]),
      .dn_negative (pneg[g+1]),
      .dn_bcd      (pbcd[g+1]),
      .dn_bin      (pbin[g+1])
    );
  end

  // highest nonzero digit, zero keeps one digit
  always_comb begin
    msd = '0;
    for (int i = 1; i < NDIG; i++) begin
      if (pbcd[NSTAGE][i*4 +: 4] != 4'd0) begin
        msd = POS_W'(i);
      end
    end
  end

  assign out_load   = !char_valid || char_ready;
  assign take       = !ev || (out_load && !eneg && epos == '0);
  assign pr[NSTAGE] = take;
  assign digit      = ebcd[epos*4 +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      ev         <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (out_load) begin
        char_valid <= ev;
      end
      if (ev && out_load && !eneg && epos == '0) begin
        ev <= 1'b0;
      end
      if (pv[NSTAGE] && take) begin
        ev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pv[NSTAGE] && take) begin
      eneg <= pneg[NSTAGE];
      epos <= msd;
      ebcd <= pbcd[NSTAGE];
    end else if (ev && out_load) begin
      if (eneg) begin
        eneg <= 1'b0;
      end else begin
        epos <= epos - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev && out_load) begin
      character <= eneg ? CHAR_MINUS : CHAR_ZERO + {4'h0, digit};
      last      <= !eneg && epos == '0;
    end
  end

`ifndef SYNTHESIS
  a_mid_word_holds_item: assert property (@(posedge clk) disable iff (rst)
    char_valid && !last |-> ev)
    else $error("non-final character word without a held value");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && character == CHAR_MINUS |-> !last)
    else $error("sign word flagged last");

  a_pipe_stall_holds: assert property (@(posedge clk) disable iff (rst)
    pv[NSTAGE] && !pr[NSTAGE] |=> pv[NSTAGE] && $stable(pbcd[NSTAGE]))
    else $error("stalled conversion result changed");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ev |-> epos <= POS_W'(NDIG - 1))
    else $error("digit position out of range");
`endif

endmodule

FILE: tb/signed_int_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_checker
  import sidec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               value_valid,
  input  logic               value_ready,
  input  logic signed [31:0] value,
  input  logic               char_valid,
  input  logic               char_ready,
  input  char_t              character,
  input  logic               last,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    char_t ch;
    logic  fin;
  } text_word_t;

  text_word_t text_q[$];
  text_word_t expected_word;

  function automatic void spell_value(input logic [31:0] v);
    logic [31:0] magnitude;
    char_t       digits[$];
    magnitude = v[31] ? (~v + 32'd1) : v;
    do begin
      digits.push_front(CHAR_ZERO + char_t'(magnitude % 32'd10));
      magnitude = magnitude / 32'd10;
    end while (magnitude != 0);
    if (v[31]) text_q.push_back('{ch: CHAR_MINUS, fin: 1'b0});
    foreach (digits[i]) text_q.push_back('{ch: digits[i], fin: (i == digits.size() - 1)});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (value_valid && value_ready) spell_value(value);
      if (char_valid && char_ready) begin
        if (text_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word character=%h last=%b", $realtime, character, last);
          mismatches++;
        end else begin
          expected_word = text_q.pop_front();
          if (character !== expected_word.ch || last !== expected_word.fin) begin
            if (mismatches < 10)
              $display("%0t: mismatch character exp=%h got=%h last exp=%b got=%b",
                       $realtime, expected_word.ch, character, expected_word.fin, last);
            mismatches++;
          end
        end
      end
      outstanding = text_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sidec_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_COUNT = 430;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               value_valid = 1'b0;
  logic               value_ready;
  logic signed [31:0] value = '0;
  logic               char_valid;
  logic               char_ready = 1'b0;
  char_t              character;
  logic               last;
  logic               quiet = 1'b0;
  int                 mismatches;
  int                 outstanding;
  int                 stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_int_to_decimal_ascii_core uut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .character   (character),
    .last        (last)
  );

  signed_int_to_decimal_ascii_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .character   (character),
    .last        (last),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(negedge clk) begin
    char_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    if ((value_valid && value_ready) || (char_valid && char_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int unsigned       kind;
    longint unsigned   span;
    longint unsigned   mag;
    logic [31:0]       v;
    kind = $urandom_range(0, 99);
    span = 1;
    if (kind < 35) begin
      v = $urandom();
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 10)) span = span * 10;
      mag = {$urandom(), $urandom()} % span;
      if (mag > 64'd2147483647) mag = mag % 64'd2147483648;
      v = mag[31:0];
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind < 92) begin
      repeat ($urandom_range(0, 9)) span = span * 10;
      v = span[31:0] + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) v = -v;
    end else if (kind < 96) begin
      v = 32'h7fff_ffff - $urandom_range(0, 3);
    end else begin
      v = 32'h8000_0000 + $urandom_range(0, 3);
    end
    return v;
  endfunction

  task automatic send_value(input logic [31:0] v);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      value_valid = 1'b0;
      @(negedge clk);
    end
    value_valid = 1'b1;
    value = v;
    @(posedge clk);
    while (!value_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                 -32'd100, 32'd999999999, 32'd1000000000, -32'd1000000000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
                 32'haaaa_aaaa, 32'd2147483646, 32'd7};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) send_value(directed[i]);
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      quiet = (n >= 150 && n < 250);
      send_value(pick_value());
    end
    quiet = 1'b0;
    value_valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sidec_pkg.sv
hw/rtl/sidec_stage.sv
hw/rtl/signed_int_to_decimal_ascii_core.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/testbench.sv
